// ===== rtl/utf8_codepoint_at_index_top_macros.svh =====
// Assertion macros for the RTL; only the decoder (u8cp_decode) includes them.
`ifndef UTF8_CODEPOINT_AT_INDEX_TOP_MACROS_SVH
`define UTF8_CODEPOINT_AT_INDEX_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define U8CP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define U8CP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/u8cp_pkg.sv =====
package u8cp_pkg;

	// Result status codes
	localparam logic [1:0] ST_FOUND     = 2'd0;
	localparam logic [1:0] ST_INVALID   = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	// Code point for an invalid or missing character (-1)
	localparam logic signed [21:0] CP_NONE = '1;

	// Lead and continuation byte patterns
	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] LEAD2_MASK  = 8'hE0;
	localparam logic [7:0] LEAD2_PAT   = 8'hC0;
	localparam logic [7:0] LEAD2_BITS  = 8'h1F;
	localparam logic [7:0] LEAD3_MASK  = 8'hF0;
	localparam logic [7:0] LEAD3_PAT   = 8'hE0;
	localparam logic [7:0] LEAD3_BITS  = 8'h0F;
	localparam logic [7:0] LEAD4_MASK  = 8'hF8;
	localparam logic [7:0] LEAD4_PAT   = 8'hF0;
	localparam logic [7:0] LEAD4_BITS  = 8'h07;
	localparam logic [7:0] CONT_MASK   = 8'hC0;
	localparam logic [7:0] CONT_PAT    = 8'h80;
	localparam logic [7:0] CONT_BITS   = 8'h3F;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [15:0] target_index;
	} in_word_t;

	typedef struct packed {
		logic signed [21:0] codepoint;
		logic [1:0]         status;
	} out_word_t;

	// Result handed from the decoder to the output register
	typedef struct packed {
		logic      vld;
		out_word_t word;
	} result_t;

endpackage

// ===== rtl/utf8_codepoint_at_index_top.sv =====
// Code point at a character index of a UTF-8 string.
// Byte channel (byte_valid/byte_stall/byte_word): one string byte per word,
// target_index taken from the first byte of each string; a zero byte or a
// word with last_byte set ends the string. An empty string is one zero byte.
// Result channel (cp_valid/cp_stall/cp_word): exactly one word per string,
// the target code point (status found), or -1 with status invalid or not
// found. A result may leave before the string ends; the end then adds none.
// Throughput: one byte per cycle while no stalled result is waiting. A result
// is registered: the byte that settles it sits in the input register,
// then decodes into the result register once that register can load.
// Per-string decode state is a single register set updated once per byte.
// When cp_stall is high with a result waiting, byte_stall is high whenever
// the input register holds a byte; at most one more byte is taken, and
// only if that register was empty. Inputs flow again once the result leaves.
// Reset (arst_n low) empties both registers and clears the decode state;
// the next byte taken is the first byte of a string.
module utf8_codepoint_at_index_top #(
	parameter int MAX_CHARS = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  u8cp_pkg::in_word_t  byte_word,
	output logic                cp_valid,
	input  logic                cp_stall,
	output u8cp_pkg::out_word_t cp_word
);

	logic               vld_s1;
	u8cp_pkg::in_word_t word_s1;
	logic               advance;
	logic               proc;
	u8cp_pkg::result_t  res;

	// Decode the held byte when the result register can take its outcome
	assign proc = vld_s1 && advance;

	u8cp_in_reg u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_word  (byte_word),
		.advance    (advance),
		.vld_s1     (vld_s1),
		.word_s1    (word_s1)
	);

	u8cp_decode #(
		.MAX_CHARS (MAX_CHARS)
	) u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.proc    (proc),
		.word_s1 (word_s1),
		.res     (res)
	);

	u8cp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.proc     (proc),
		.advance  (advance),
		.cp_valid (cp_valid),
		.cp_stall (cp_stall),
		.cp_word  (cp_word)
	);

endmodule

// ===== rtl/u8cp_in_reg.sv =====
module u8cp_in_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  u8cp_pkg::in_word_t byte_word,
	input  logic               advance,
	output logic               vld_s1,
	output u8cp_pkg::in_word_t word_s1
);

	// Hold the stage only while it is full and cannot move on
	assign byte_stall = vld_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!byte_stall) begin
			vld_s1 <= byte_valid;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			word_s1 <= byte_word;
		end
	end

endmodule

// ===== rtl/u8cp_decode.sv =====
`include "utf8_codepoint_at_index_top_macros.svh"

module u8cp_decode #(
	parameter int MAX_CHARS = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               proc,
	input  u8cp_pkg::in_word_t word_s1,
	output u8cp_pkg::result_t  res
);

	localparam int CW = $clog2(MAX_CHARS + 1);
	localparam int EW = (CW > 16) ? CW : 16;
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_CHARS);

	logic [CW-1:0] char_count_q;
	logic [1:0]    bytes_left_q;
	logic [20:0]   partial_code_q;
	logic          char_invalid_q;
	logic          answer_given_q;
	logic          string_started_q;
	logic [15:0]   wanted_index_q;

	logic [CW-1:0] cnt_e, cnt_n;
	logic [1:0]    bl_e, bl_n;
	logic [20:0]   pc_e, pc_n;
	logic          inv_e, inv_n;
	logic          ag_e, ag_n;
	logic [15:0]   want_e;
	logic          done;
	logic          at_now, at_end;
	logic          str_end;
	logic [7:0]    b;

	assign b = word_s1.data_byte;

	// Effective state: a first byte starts from a clean slate
	always_comb begin
		if (!string_started_q) begin
			want_e = word_s1.target_index;
			cnt_e  = '0;
			bl_e   = '0;
			pc_e   = '0;
			inv_e  = 1'b0;
			ag_e   = 1'b0;
		end else begin
			want_e = wanted_index_q;
			cnt_e  = char_count_q;
			bl_e   = bytes_left_q;
			pc_e   = partial_code_q;
			inv_e  = char_invalid_q;
			ag_e   = answer_given_q;
		end
	end

	assign at_now  = (cnt_e < CNT_MAX) && (EW'(cnt_e) == EW'(want_e));
	assign str_end = (b == 8'd0) || word_s1.last_byte;

	// Byte decode, character completion and string end
	always_comb begin
		cnt_n = cnt_e;
		bl_n  = bl_e;
		pc_n  = pc_e;
		inv_n = inv_e;
		ag_n  = ag_e;
		done  = 1'b0;
		res.vld  = 1'b0;
		res.word = '{codepoint: u8cp_pkg::CP_NONE, status: u8cp_pkg::ST_NOT_FOUND};
		at_end = 1'b0;

		if (b != 8'd0) begin
			if (bl_e == 2'd0) begin
				inv_n = 1'b0;
				if (b < u8cp_pkg::ASCII_LIMIT) begin
					pc_n = 21'(b);
					done = 1'b1;
				end else if ((b & u8cp_pkg::LEAD2_MASK) == u8cp_pkg::LEAD2_PAT) begin
					pc_n = 21'(b & u8cp_pkg::LEAD2_BITS);
					bl_n = 2'd1;
				end else if ((b & u8cp_pkg::LEAD3_MASK) == u8cp_pkg::LEAD3_PAT) begin
					pc_n = 21'(b & u8cp_pkg::LEAD3_BITS);
					bl_n = 2'd2;
				end else if ((b & u8cp_pkg::LEAD4_MASK) == u8cp_pkg::LEAD4_PAT) begin
					pc_n = 21'(b & u8cp_pkg::LEAD4_BITS);
					bl_n = 2'd3;
				end else begin
					// bad lead: one invalid character
					pc_n  = '0;
					inv_n = 1'b1;
					done  = 1'b1;
				end
			end else begin
				if ((b & u8cp_pkg::CONT_MASK) != u8cp_pkg::CONT_PAT) begin
					inv_n = 1'b1;
				end else begin
					pc_n = {pc_e[14:0], b[5:0]};
				end
				bl_n = bl_e - 2'd1;
				done = (bl_e == 2'd1);
			end

			if (done) begin
				if (!ag_e && at_now) begin
					res.vld = 1'b1;
					ag_n    = 1'b1;
					if (inv_n) begin
						res.word.codepoint = u8cp_pkg::CP_NONE;
						res.word.status    = u8cp_pkg::ST_INVALID;
					end else begin
						res.word.codepoint = {1'b0, pc_n};
						res.word.status    = u8cp_pkg::ST_FOUND;
					end
				end
				if (cnt_e < CNT_MAX) begin
					cnt_n = cnt_e + CW'(1);
				end
				inv_n = 1'b0;
			end
		end

		// End of string: report once if nothing was given
		if (str_end) begin
			at_end = (cnt_n < CNT_MAX) && (EW'(cnt_n) == EW'(want_e));
			if (!ag_n) begin
				res.vld            = 1'b1;
				ag_n               = 1'b1;
				res.word.codepoint = u8cp_pkg::CP_NONE;
				res.word.status    = ((bl_n != 2'd0) && at_end) ?
					u8cp_pkg::ST_INVALID : u8cp_pkg::ST_NOT_FOUND;
			end
			bl_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q     <= '0;
			bytes_left_q     <= '0;
			partial_code_q   <= '0;
			char_invalid_q   <= 1'b0;
			answer_given_q   <= 1'b0;
			string_started_q <= 1'b0;
			wanted_index_q   <= '0;
		end else if (proc) begin
			char_count_q     <= cnt_n;
			bytes_left_q     <= bl_n;
			partial_code_q   <= pc_n;
			char_invalid_q   <= inv_n;
			answer_given_q   <= ag_n;
			string_started_q <= !str_end;
			wanted_index_q   <= want_e;
		end
	end

	`U8CP_ASSERT_NOW(a_idle_no_pending, !string_started_q, bytes_left_q == 2'd0, "pending bytes with no string")
	`U8CP_ASSERT_NOW(a_count_bound, 1'b1, char_count_q <= CNT_MAX, "character count past saturation")
	`U8CP_ASSERT_NOW(a_fail_all_ones, proc && res.vld && (res.word.status != u8cp_pkg::ST_FOUND), res.word.codepoint == u8cp_pkg::CP_NONE, "failed result without -1")
	`U8CP_ASSERT_NEXT(a_end_once, proc && str_end, !string_started_q && !answer_given_q || !string_started_q, "string did not close")

endmodule

// ===== rtl/u8cp_out_reg.sv =====
module u8cp_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  u8cp_pkg::result_t   res,
	input  logic                proc,
	output logic                advance,
	output logic                cp_valid,
	input  logic                cp_stall,
	output u8cp_pkg::out_word_t cp_word
);

	// Result register may load when empty or being taken
	assign advance = !cp_valid || !cp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_valid <= 1'b0;
		end else if (advance) begin
			cp_valid <= proc && res.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && proc && res.vld) begin
			cp_word <= res.word;
		end
	end

endmodule

// ===== bench/utf8_codepoint_at_index_top_tb.sv =====
module utf8_codepoint_at_index_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_CHARS      = 65536;
	localparam int DIR_ROWS       = 25;
	localparam int BURST_BYTES    = 40;
	localparam int HOLD_CYCLES    = 48;
	localparam int PHASE_BYTES    = 296;
	localparam int TAIL_CYCLES    = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam bit NO_CHECK       = 1'b0;
	localparam bit TYPED          = 1'b1;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                byte_valid = 1'b0;
	logic                byte_stall;
	u8cp_pkg::in_word_t  byte_word = '0;
	logic                cp_valid;
	logic                cp_stall = 1'b0;
	u8cp_pkg::out_word_t cp_word;

	// Pacing knobs, per phase
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	bit hold_req = 1'b0;

	// Bookkeeping
	u8cp_pkg::out_word_t expected_cps[$];
	logic [7:0]          str_bytes[$];
	u8cp_pkg::out_word_t want;
	int errors = 0;
	int bytes_sent = 0;
	int strings_sent = 0;
	int results_checked = 0;
	int idle_cycles = 0;

	// Decoder state mirrored by the predictor
	logic [16:0] n_chars = '0;
	logic [1:0]  pend_bytes = '0;
	logic [20:0] acc_code = '0;
	bit          bad_char = 1'b0;
	bit          answered = 1'b0;
	bit          in_string = 1'b0;
	logic [15:0] want_idx = '0;

	// Directed table: byte, last, target, typed?, expected code point, status
	typedef struct packed {
		logic [7:0]         data_byte;
		logic               last_byte;
		logic [15:0]        target_index;
		logic               typed;
		logic signed [21:0] exp_cp;
		logic [1:0]         exp_st;
	} dir_row_t;

	dir_row_t directed_rows [DIR_ROWS] = '{
		// empty string
		'{8'h00, 1'b0, 16'h0000, TYPED, u8cp_pkg::CP_NONE, u8cp_pkg::ST_NOT_FOUND},
		// single ASCII char
		'{8'h41, 1'b1, 16'h0000, TYPED, 22'h000041, u8cp_pkg::ST_FOUND},
		// bad lead byte alone
		'{8'hFF, 1'b1, 16'h0000, TYPED, u8cp_pkg::CP_NONE, u8cp_pkg::ST_INVALID},
		// two-byte max
		'{8'hDF, 1'b0, 16'h0000, NO_CHECK, '0, '0},
		'{8'hBF, 1'b1, 16'h0000, NO_CHECK, '0, '0},
		// three-byte max
		'{8'hEF, 1'b0, 16'h0000, NO_CHECK, '0, '0},
		'{8'hBF, 1'b0, 16'h0000, NO_CHECK, '0, '0},
		'{8'hBF, 1'b1, 16'h0000, NO_CHECK, '0, '0},
		// four-byte max, target done on the last byte
		'{8'hF7, 1'b0, 16'h0000, NO_CHECK, '0, '0},
		'{8'hBF, 1'b0, 16'h0000, NO_CHECK, '0, '0},
		'{8'hBF, 1'b0, 16'h0000, NO_CHECK, '0, '0},
		'{8'hBF, 1'b1, 16'h0000, TYPED, 22'h1FFFFF, u8cp_pkg::ST_FOUND},
		// bad continuation, count still consumed
		'{8'hE2, 1'b0, 16'h0000, NO_CHECK, '0, '0},
		'{8'h41, 1'b0, 16'h0000, NO_CHECK, '0, '0},
		'{8'h82, 1'b1, 16'h0000, TYPED, u8cp_pkg::CP_NONE, u8cp_pkg::ST_INVALID},
		// zero byte inside a char
		'{8'hC3, 1'b0, 16'h0000, NO_CHECK, '0, '0},
		'{8'h00, 1'b0, 16'h0000, TYPED, u8cp_pkg::CP_NONE, u8cp_pkg::ST_INVALID},
		// last flag inside a char
		'{8'hF0, 1'b0, 16'h0000, NO_CHECK, '0, '0},
		'{8'h90, 1'b1, 16'h0000, TYPED, u8cp_pkg::CP_NONE, u8cp_pkg::ST_INVALID},
		// zero byte that is also last
		'{8'h00, 1'b1, 16'h0000, TYPED, u8cp_pkg::CP_NONE, u8cp_pkg::ST_NOT_FOUND},
		// top target never reached; target only taken on the first byte
		'{8'h7F, 1'b0, 16'hFFFF, NO_CHECK, '0, '0},
		'{8'hFE, 1'b1, 16'h0000, TYPED, u8cp_pkg::CP_NONE, u8cp_pkg::ST_NOT_FOUND},
		// bytes after the answer give nothing more
		'{8'h41, 1'b0, 16'h0000, TYPED, 22'h000041, u8cp_pkg::ST_FOUND},
		'{8'h42, 1'b0, 16'h0000, NO_CHECK, '0, '0},
		'{8'h00, 1'b0, 16'h0000, NO_CHECK, '0, '0}
	};

	int idle_pct_tab [4] = '{0, 60, 0, 6};
	int stall_pct_tab [4] = '{0, 0, 60, 6};

	utf8_codepoint_at_index_top #(
		.MAX_CHARS(MAX_CHARS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_word(byte_word),
		.cp_valid(cp_valid),
		.cp_stall(cp_stall),
		.cp_word(cp_word)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor
	function automatic bit at_wanted();
		return (n_chars < MAX_CHARS) && (n_chars == {1'b0, want_idx});
	endfunction

	// String end: report not found (or invalid if cut inside the target)
	task automatic close_string(output bit got, output u8cp_pkg::out_word_t res);
		got = 1'b0;
		res = '0;
		if (!answered) begin
			got = 1'b1;
			res.codepoint = u8cp_pkg::CP_NONE;
			res.status = (pend_bytes != 0 && at_wanted()) ?
				u8cp_pkg::ST_INVALID : u8cp_pkg::ST_NOT_FOUND;
			answered = 1'b1;
		end
		in_string = 1'b0;
		pend_bytes = '0;
	endtask

	task automatic decode_byte(input u8cp_pkg::in_word_t w, output bit got,
			output u8cp_pkg::out_word_t res);
		bit done;
		bit end_got;
		u8cp_pkg::out_word_t end_res;
		logic [7:0] b;
		b = w.data_byte;
		done = 1'b0;
		got = 1'b0;
		res = '0;
		if (!in_string) begin
			want_idx = w.target_index;
			n_chars = '0;
			pend_bytes = '0;
			acc_code = '0;
			bad_char = 1'b0;
			answered = 1'b0;
			in_string = 1'b1;
		end
		if (b == 8'h00) begin
			close_string(got, res);
		end else begin
			// lead byte or continuation
			if (pend_bytes == 0) begin
				bad_char = 1'b0;
				if (b < u8cp_pkg::ASCII_LIMIT) begin
					acc_code = {13'd0, b};
					done = 1'b1;
				end else if ((b & u8cp_pkg::LEAD2_MASK) == u8cp_pkg::LEAD2_PAT) begin
					acc_code = {13'd0, b & u8cp_pkg::LEAD2_BITS};
					pend_bytes = 2'd1;
				end else if ((b & u8cp_pkg::LEAD3_MASK) == u8cp_pkg::LEAD3_PAT) begin
					acc_code = {13'd0, b & u8cp_pkg::LEAD3_BITS};
					pend_bytes = 2'd2;
				end else if ((b & u8cp_pkg::LEAD4_MASK) == u8cp_pkg::LEAD4_PAT) begin
					acc_code = {13'd0, b & u8cp_pkg::LEAD4_BITS};
					pend_bytes = 2'd3;
				end else begin
					acc_code = '0;
					bad_char = 1'b1;
					done = 1'b1;
				end
			end else begin
				if ((b & u8cp_pkg::CONT_MASK) != u8cp_pkg::CONT_PAT)
					bad_char = 1'b1;
				else
					acc_code = {acc_code[14:0], b[5:0]};
				pend_bytes = pend_bytes - 2'd1;
				if (pend_bytes == 0)
					done = 1'b1;
			end
			// char complete
			if (done) begin
				if (!answered && at_wanted()) begin
					got = 1'b1;
					answered = 1'b1;
					if (bad_char) begin
						res.codepoint = u8cp_pkg::CP_NONE;
						res.status = u8cp_pkg::ST_INVALID;
					end else begin
						res.codepoint = {1'b0, acc_code};
						res.status = u8cp_pkg::ST_FOUND;
					end
				end
				if (n_chars < MAX_CHARS)
					n_chars = n_chars + 17'd1;
				bad_char = 1'b0;
			end
			if (w.last_byte) begin
				close_string(end_got, end_res);
				if (!got) begin
					got = end_got;
					res = end_res;
				end
			end
		end
	endtask

	// Byte channel driver: offer at negedge, hold until taken
	task automatic send_byte(input u8cp_pkg::in_word_t w, input bit typed,
			input u8cp_pkg::out_word_t typed_res);
		int gap;
		bit got;
		u8cp_pkg::out_word_t res;
		gap = 0;
		while ($urandom_range(99) < src_idle_pct)
			gap++;
		if (gap != 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_word <= w;
		byte_valid <= 1'b1;
		do
			@(posedge clk);
		while (byte_stall);
		decode_byte(w, got, res);
		if (typed)
			expected_cps.push_back(typed_res);
		else if (got)
			expected_cps.push_back(res);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Stop offering until every expected result is out
	task automatic drain();
		byte_valid <= 1'b0;
		do
			@(negedge clk);
		while (expected_cps.size() != 0);
	endtask

	// Random string: mostly well-formed chars, some noise and cut-off endings
	task automatic build_string(output logic [15:0] tgt);
		int n_ch;
		int k;
		logic [20:0] cp;
		str_bytes.delete();
		n_ch = ($urandom_range(9) == 0) ? $urandom_range(1, 30) : $urandom_range(0, 6);
		for (int c = 0; c < n_ch; c++) begin
			k = $urandom_range(99);
			cp = 21'($urandom());
			if (k < 30) begin
				str_bytes.push_back(8'($urandom_range(1, 127)));
			end else if (k < 50) begin
				str_bytes.push_back({3'b110, cp[10:6]});
				str_bytes.push_back({2'b10, cp[5:0]});
			end else if (k < 70) begin
				str_bytes.push_back({4'b1110, cp[15:12]});
				str_bytes.push_back({2'b10, cp[11:6]});
				str_bytes.push_back({2'b10, cp[5:0]});
			end else if (k < 88) begin
				str_bytes.push_back({5'b11110, cp[20:18]});
				str_bytes.push_back({2'b10, cp[17:12]});
				str_bytes.push_back({2'b10, cp[11:6]});
				str_bytes.push_back({2'b10, cp[5:0]});
			end else begin
				case ($urandom_range(2))
					0: str_bytes.push_back(8'($urandom_range(1, 255)));
					1: begin
						str_bytes.push_back({4'b1110, cp[15:12]});
						str_bytes.push_back(8'($urandom_range(1, 255)));
						str_bytes.push_back({2'b10, cp[5:0]});
					end
					default: str_bytes.push_back({5'b11110, cp[20:18]});
				endcase
			end
		end
		// sometimes end in the middle of a char
		if ($urandom_range(9) == 0) begin
			cp = 21'($urandom());
			str_bytes.push_back({4'b1110, cp[15:12]});
			if (cp[20])
				str_bytes.push_back({2'b10, cp[5:0]});
		end
		if (str_bytes.size() == 0 || $urandom_range(1) == 1)
			str_bytes.push_back(8'h00);
		k = $urandom_range(99);
		if (k < 70)
			tgt = 16'($urandom_range(0, n_ch));
		else if (k < 85)
			tgt = 16'($urandom_range(0, 15));
		else
			tgt = 16'($urandom_range(0, 16'hFFFF));
	endtask

	// Result channel stall: random per phase, or one long hold-off
	always begin
		@(negedge clk);
		if (hold_req) begin
			cp_stall <= 1'b1;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_req = 1'b0;
			cp_stall <= 1'b0;
		end else begin
			cp_stall <= ($urandom_range(99) < sink_stall_pct);
		end
	end

	// Result checker
	always @(posedge clk) begin
		if (arst_n && cp_valid && !cp_stall) begin
			if (expected_cps.size() == 0) begin
				$display("%0t: result word with none expected: cp %0d status %0d",
					$time, cp_word.codepoint, cp_word.status);
				errors++;
			end else begin
				want = expected_cps.pop_front();
				if (cp_word.codepoint !== want.codepoint) begin
					$display("%0t: codepoint expected %0d got %0d",
						$time, want.codepoint, cp_word.codepoint);
					errors++;
				end
				if (cp_word.status !== want.status) begin
					$display("%0t: status expected %0d got %0d",
						$time, want.status, cp_word.status);
					errors++;
				end
				results_checked++;
			end
		end
	end

	// Watchdog on cycles with no word moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (byte_valid && !byte_stall) || (cp_valid && !cp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d results pending",
				$time, idle_cycles, expected_cps.size());
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		u8cp_pkg::in_word_t w;
		u8cp_pkg::out_word_t typed_res;
		logic [15:0] tgt;
		int sent;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed strings
		for (int i = 0; i < DIR_ROWS; i++) begin
			w.data_byte = directed_rows[i].data_byte;
			w.last_byte = directed_rows[i].last_byte;
			w.target_index = directed_rows[i].target_index;
			typed_res.codepoint = directed_rows[i].exp_cp;
			typed_res.status = directed_rows[i].exp_st;
			send_byte(w, directed_rows[i].typed, typed_res);
			if (w.last_byte || w.data_byte == 8'h00)
				strings_sent++;
		end
		drain();

		// Long receiver hold-off while one-char strings keep coming
		hold_req = 1'b1;
		for (int i = 0; i < BURST_BYTES; i++) begin
			w.data_byte = 8'($urandom_range(1, 127));
			w.last_byte = 1'b1;
			w.target_index = '0;
			send_byte(w, NO_CHECK, '0);
			strings_sent++;
		end
		drain();

		// Random strings under each pacing mix
		for (int phase = 0; phase < 4; phase++) begin
			src_idle_pct = idle_pct_tab[phase];
			sink_stall_pct = stall_pct_tab[phase];
			sent = 0;
			while (sent < PHASE_BYTES) begin
				build_string(tgt);
				for (int j = 0; j < str_bytes.size(); j++) begin
					w.data_byte = str_bytes[j];
					w.target_index = (j == 0) ? tgt : 16'($urandom_range(0, 16'hFFFF));
					w.last_byte = (j == str_bytes.size() - 1) &&
						(str_bytes[j] != 8'h00 || $urandom_range(1) == 1);
					send_byte(w, NO_CHECK, '0);
					sent++;
				end
				strings_sent++;
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		if (expected_cps.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_cps.size());
			errors++;
		end

		$display("tb: %0d bytes in %0d strings, %0d results checked, %0d errors",
			bytes_sent, strings_sent, results_checked, errors);
		$display("tb: pacing covered free flow, sender gaps, receiver stalls, long hold-off");
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
